### src/slcdf_pkg.sv
// Shared constants, types and functions of the sky luminance CDF builder.
`default_nettype none

package slcdf_pkg;

    // Map geometry
    localparam int MAP_ROWS    = 256;
    localparam int MAP_COLUMNS = 512;
    localparam int ROW_W       = $clog2(MAP_ROWS);
    localparam int COL_W       = $clog2(MAP_COLUMNS);

    // Field widths
    localparam int CHAN_W  = 16;
    localparam int ADDR_W  = 18;
    localparam int VALUE_W = 33;
    localparam int CSUM_W  = 24;
    localparam int OPND_W  = 17;
    localparam int ACC_W   = 32;

    // Rec.709 luminance weights, Q0.16
    localparam logic [OPND_W-1:0] LUMA_R = 17'd13933;
    localparam logic [OPND_W-1:0] LUMA_G = 17'd46871;
    localparam logic [OPND_W-1:0] LUMA_B = 17'd4732;

    // Half an LSB of Q16 for round half up
    localparam logic [ACC_W-1:0] ROUND_HALF = 32'd32768;

    // Sine recurrence seeds, Q2.30
    localparam logic [63:0] SINE_STEP_Q30 = 64'd13176464;
    localparam logic [63:0] TWO_COS_Q30   = 64'd2147321946;

    typedef logic [OPND_W-1:0] t_sine_rom [0:MAP_ROWS-1];

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic en;   // update accumulator
        logic clr;  // load bias plus product instead of accumulating
    } t_mac_ctrl;

    // Sine table built at elaboration: two-term recurrence, mirrored
    function automatic t_sine_rom build_sine();
        t_sine_rom   rom;
        logic [63:0] prev;
        logic [63:0] cur;
        logic [63:0] nxt;
        logic [63:0] q;
        logic [OPND_W-1:0] val;
        rom  = '{default: '0};
        prev = 64'd0;
        cur  = SINE_STEP_Q30;
        for (int k = 1; k <= MAP_ROWS / 2; k++) begin
            q   = (cur + 64'd8192) >> 14;
            val = (q > 64'd65536) ? 17'd65536 : q[OPND_W-1:0];
            rom[k]            = val;
            rom[MAP_ROWS - k] = val;
            nxt  = ((TWO_COS_Q30 * cur + 64'd536870912) >> 30) - prev;
            prev = cur;
            cur  = nxt;
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine();

    // 8-bit bit reversal
    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] x;
        for (int i = 0; i < 8; i++) begin
            x[i] = v[7 - i];
        end
        return x;
    endfunction

endpackage

`default_nettype wire

### src/slcdf_mac.sv
// Shared 17x17 multiply-accumulate unit with round-half bias on load.
`default_nettype none

module slcdf_mac (
    input  wire                                i_clk,
    input  wire slcdf_pkg::t_mac_ctrl          i_ctrl,
    input  wire [slcdf_pkg::OPND_W-1:0]        i_a,
    input  wire [slcdf_pkg::OPND_W-1:0]        i_b,
    output logic [slcdf_pkg::ACC_W-1:0]        o_acc
);

    logic [2*slcdf_pkg::OPND_W-1:0] w_prod;
    logic [slcdf_pkg::ACC_W-1:0]    w_prod_t;
    logic [slcdf_pkg::ACC_W-1:0]    r_acc;
    logic [slcdf_pkg::ACC_W-1:0]    n_acc;

    // Product always fits 32 bits for the operand ranges used here
    assign w_prod   = i_a * i_b;
    assign w_prod_t = w_prod[slcdf_pkg::ACC_W-1:0];

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.en) begin
            n_acc = (i_ctrl.clr ? slcdf_pkg::ROUND_HALF : r_acc) + w_prod_t;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

### src/sky_luminance_cdf_builder_core.sv
// Top level: texel sequencer, running sums, address generation and output register.
//
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tdata: red, green, blue
// m_axis    out  tvalid/tready        tdata: address, cdf value; tuser: table; tlast
//
// A texel takes four products on the shared multiplier (three luminance products, then
// the sine weighting), the first overlapping the accept, and then writes one to three
// results. All products go through the single multiplier.
// Reset (i_rst_n low, synchronous) clears row, column and both running sums.
// A stalled output holds the sequencer; the next texel may be taken while the
// final result of the previous one still waits in the output register.
`default_nettype none

module sky_luminance_cdf_builder_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [47:0] i_s_axis_tdata,   // red [15:0], green [31:16], blue [47:32]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // write_address [17:0], cdf_value [50:18], zero
    output logic        o_m_axis_tuser,   // target_table [0]
    output logic        o_m_axis_tlast    // last_write
);

    localparam int ROW_W   = slcdf_pkg::ROW_W;
    localparam int COL_W   = slcdf_pkg::COL_W;
    localparam int CHAN_W  = slcdf_pkg::CHAN_W;
    localparam int ADDR_W  = slcdf_pkg::ADDR_W;
    localparam int VALUE_W = slcdf_pkg::VALUE_W;
    localparam int CSUM_W  = slcdf_pkg::CSUM_W;
    localparam int OPND_W  = slcdf_pkg::OPND_W;
    localparam int ACC_W   = slcdf_pkg::ACC_W;

    localparam logic [ROW_W-1:0]  ROW_LAST      = ROW_W'(slcdf_pkg::MAP_ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST      = COL_W'(slcdf_pkg::MAP_COLUMNS - 1);
    localparam logic [ADDR_W-1:0] COL_ADDR_ZERO = ADDR_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        K_MAP_START,
        K_COL_START,
        K_TEXEL,
        K_COL_END
    } t_kind;

    t_state              r_state;
    t_kind               r_kind;
    logic [1:0]          r_step;
    logic [CHAN_W-1:0]   r_green;
    logic [CHAN_W-1:0]   r_blue;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [CSUM_W-1:0]   r_col_sum;
    logic [VALUE_W-1:0]  r_grand_sum;

    logic                r_out_valid;
    logic                r_out_table;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_last;

    slcdf_pkg::t_mac_ctrl w_mac_ctrl;
    logic [OPND_W-1:0]   w_mac_a;
    logic [OPND_W-1:0]   w_mac_b;
    logic [ACC_W-1:0]    w_acc;

    logic                w_in_accept;
    logic                w_out_free;
    logic                w_emit;
    logic [CHAN_W-1:0]   w_weight;
    logic [CSUM_W-1:0]   w_col_sum_add;
    logic [VALUE_W-1:0]  w_grand_add;
    logic [ADDR_W-1:0]   w_base;
    logic [ROW_W-1:0]    w_row_next;
    logic [ROW_W:0]      w_row_addr;
    logic [COL_W-1:0]    w_col_next;
    logic [COL_W:0]      w_col_addr;

    logic                w_res_table;
    logic [ADDR_W-1:0]   w_res_addr;
    logic [VALUE_W-1:0]  w_res_value;
    logic                w_res_last;

    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_emit          = (r_state == S_EMIT) && w_out_free;

    // Operand selection for the shared multiplier
    always_comb begin
        w_mac_ctrl = '0;
        w_mac_a    = '0;
        w_mac_b    = '0;
        case (r_state)
            S_IDLE: begin
                w_mac_ctrl.en  = w_in_accept;
                w_mac_ctrl.clr = 1'b1;
                w_mac_a        = {1'b0, i_s_axis_tdata[CHAN_W-1:0]};
                w_mac_b        = slcdf_pkg::LUMA_R;
            end
            S_MUL: begin
                w_mac_ctrl.en = 1'b1;
                case (r_step)
                    2'd1: begin
                        w_mac_a = {1'b0, r_green};
                        w_mac_b = slcdf_pkg::LUMA_G;
                    end
                    2'd2: begin
                        w_mac_a = {1'b0, r_blue};
                        w_mac_b = slcdf_pkg::LUMA_B;
                    end
                    default: begin
                        // luminance is already rounded by the bias
                        w_mac_ctrl.clr = 1'b1;
                        w_mac_a        = {1'b0, w_acc[ACC_W-1:ACC_W-CHAN_W]};
                        w_mac_b        = slcdf_pkg::SINE_ROM[r_row];
                    end
                endcase
            end
            default: begin
                w_mac_ctrl = '0;
            end
        endcase
    end

    slcdf_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (w_mac_ctrl),
        .i_a    (w_mac_a),
        .i_b    (w_mac_b),
        .o_acc  (w_acc)
    );

    // Sums and addresses
    assign w_weight      = w_acc[ACC_W-1:ACC_W-CHAN_W];
    assign w_col_sum_add = r_col_sum + {{(CSUM_W-CHAN_W){1'b0}}, w_weight};
    assign w_grand_add   = r_grand_sum + {{(VALUE_W-CSUM_W){1'b0}}, r_col_sum};
    assign w_base        = {1'b0, r_col, {ROW_W{1'b0}}} + {{(ADDR_W-COL_W){1'b0}}, r_col};
    assign w_row_next    = r_row + 1'b1;
    assign w_row_addr    = (r_row == ROW_LAST) ? '0
                         : {1'b0, slcdf_pkg::rev8(w_row_next)} + 1'b1;
    assign w_col_next    = r_col + 1'b1;
    assign w_col_addr    = (r_col == COL_LAST) ? '0
                         : {1'b0, slcdf_pkg::rev8(w_col_next[7:0]), w_col_next[8]} + 1'b1;

    // Result for the current kind
    always_comb begin
        w_res_table = 1'b0;
        w_res_addr  = '0;
        w_res_value = '0;
        w_res_last  = 1'b0;
        case (r_kind)
            K_MAP_START: begin
                w_res_table = 1'b1;
                w_res_addr  = COL_ADDR_ZERO;
            end
            K_COL_START: begin
                w_res_addr = w_base + ADDR_W'(1);
            end
            K_TEXEL: begin
                w_res_addr  = w_base + {{(ADDR_W-ROW_W-1){1'b0}}, w_row_addr};
                w_res_value = {{(VALUE_W-CSUM_W){1'b0}}, w_col_sum_add};
                w_res_last  = (r_row != ROW_LAST);
            end
            default: begin
                w_res_table = 1'b1;
                w_res_addr  = {{(ADDR_W-COL_W-1){1'b0}}, w_col_addr};
                w_res_value = w_grand_add;
                w_res_last  = 1'b1;
            end
        endcase
    end

    // Sequencer, running state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= K_TEXEL;
            r_step      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_col_sum   <= '0;
            r_grand_sum <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register fills on emit, empties when taken
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_green <= i_s_axis_tdata[2*CHAN_W-1:CHAN_W];
                        r_blue  <= i_s_axis_tdata[3*CHAN_W-1:2*CHAN_W];
                        r_step  <= 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd3) begin
                        if (r_row == '0 && r_col == '0) begin
                            r_kind <= K_MAP_START;
                        end else if (r_row == '0) begin
                            r_kind <= K_COL_START;
                        end else begin
                            r_kind <= K_TEXEL;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_table <= w_res_table;
                        r_out_addr  <= w_res_addr;
                        r_out_value <= w_res_value;
                        r_out_last  <= w_res_last;
                        case (r_kind)
                            K_MAP_START: begin
                                r_grand_sum <= '0;
                                r_kind      <= K_COL_START;
                            end
                            K_COL_START: begin
                                r_col_sum <= '0;
                                r_kind    <= K_TEXEL;
                            end
                            K_TEXEL: begin
                                r_col_sum <= w_col_sum_add;
                                if (r_row == ROW_LAST) begin
                                    r_kind <= K_COL_END;
                                end else begin
                                    r_row   <= w_row_next;
                                    r_state <= S_IDLE;
                                end
                            end
                            default: begin
                                r_grand_sum <= w_grand_add;
                                r_row       <= '0;
                                r_col       <= w_col_next;
                                r_state     <= S_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(56-ADDR_W-VALUE_W){1'b0}}, r_out_value, r_out_addr};
    assign o_m_axis_tuser  = r_out_table;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

### tb/cdf_write_checker.sv
// Checker for the sky luminance CDF builder: predicts table writes and compares them.
module cdf_write_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,    // red [15:0], green [31:16], blue [47:32]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,    // write_address [17:0], cdf_value [50:18], zero
    input  logic        i_m_tuser,    // target_table [0]
    input  logic        i_m_tlast,
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS    = slcdf_pkg::MAP_ROWS;
    localparam int COLUMNS = slcdf_pkg::MAP_COLUMNS;

    // Rec.709 weights in Q0.16
    localparam bit [63:0] COEF_RED   = 64'd13933;
    localparam bit [63:0] COEF_GREEN = 64'd46871;
    localparam bit [63:0] COEF_BLUE  = 64'd4732;

    // Sine recurrence in Q2.30
    localparam bit [63:0] SINE_SEED_Q30 = 64'd13176464;
    localparam bit [63:0] TWICE_COS_Q30 = 64'd2147321946;

    // Destination tables
    localparam bit TABLE_COLUMN = 1'b0;
    localparam bit TABLE_TOTALS = 1'b1;

    typedef struct packed {
        logic        to_table;
        logic [17:0] address;
        logic [32:0] value;
        logic        is_last;
    } cdf_write_t;

    cdf_write_t        pending_writes [$];
    bit [16:0]         sine_q16 [ROWS];
    bit [7:0]          row_pos;
    bit [8:0]          col_pos;
    bit [23:0]         column_sum;
    bit [32:0]         grand_sum;
    int                mismatch_count = 0;

    // Sine weights per row: recurrence, rounded to Q1.16, clamped, mirrored
    initial begin : build_sine
        bit [63:0] s_prev;
        bit [63:0] s_cur;
        bit [63:0] s_next;
        bit [63:0] q16;
        s_prev      = '0;
        s_cur       = SINE_SEED_Q30;
        sine_q16[0] = '0;
        for (int k = 1; k <= ROWS / 2; k++) begin
            q16 = (s_cur + 64'd8192) >> 14;
            if (q16 > 64'd65536) q16 = 64'd65536;
            sine_q16[k]        = q16[16:0];
            sine_q16[ROWS - k] = q16[16:0];
            s_next = ((TWICE_COS_Q30 * s_cur + 64'd536870912) >> 30) - s_prev;
            s_prev = s_cur;
            s_cur  = s_next;
        end
    end

    function automatic bit [7:0] mirror8(input bit [7:0] v);
        bit [7:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) m = {m[6:0], v[i]};
        return m;
    endfunction

    // Slot of boundary v within one column's table; v == ROWS is the wrap slot
    function automatic int unsigned row_slot(input int unsigned v);
        return (v >= ROWS) ? 0 : mirror8(v[7:0]) + 1;
    endfunction

    // Slot of column boundary v in the totals table, 9-bit radical inverse
    function automatic int unsigned column_slot(input int unsigned v);
        bit [8:0] rv;
        if (v >= COLUMNS) return 0;
        rv = {mirror8(v[7:0]), v[8]};
        return rv + 1;
    endfunction

    // Expected writes caused by one accepted texel
    task automatic predict_texel(input logic [47:0] texel);
        bit [63:0]   luma;
        bit [63:0]   weight;
        int unsigned base;
        cdf_write_t  batch [3];
        int          n;
        n      = 0;
        base   = col_pos * (ROWS + 1);
        luma   = (64'(texel[15:0]) * COEF_RED + 64'(texel[31:16]) * COEF_GREEN
                  + 64'(texel[47:32]) * COEF_BLUE + 64'd32768) >> 16;
        weight = (luma * 64'(sine_q16[row_pos]) + 64'd32768) >> 16;

        // map start: totals table reopens with a zero entry
        if (row_pos == 0 && col_pos == 0) begin
            grand_sum = '0;
            batch[n]  = '{TABLE_TOTALS, 18'(column_slot(0)), 33'd0, 1'b0};
            n++;
        end
        // column start: zero entry of this column
        if (row_pos == 0) begin
            column_sum = '0;
            batch[n]   = '{TABLE_COLUMN, 18'(base + row_slot(0)), 33'd0, 1'b0};
            n++;
        end
        column_sum = column_sum + weight[23:0];
        batch[n]   = '{TABLE_COLUMN, 18'(base + row_slot(row_pos + 1)), 33'(column_sum), 1'b0};
        n++;
        // column end: running grand total, then advance to the next column
        if (row_pos == ROWS - 1) begin
            grand_sum = grand_sum + 33'(column_sum);
            batch[n]  = '{TABLE_TOTALS, 18'(column_slot(col_pos + 1)), grand_sum, 1'b0};
            n++;
            col_pos   = col_pos + 1'b1;
        end
        row_pos = row_pos + 1'b1;

        batch[n - 1].is_last = 1'b1;
        for (int i = 0; i < n; i++) pending_writes.push_back(batch[i]);
    endtask

    // Watch both channels: compare each accepted write, then take the new request
    always @(posedge i_clk) begin : monitor
        cdf_write_t got;
        cdf_write_t want;
        if (!i_rst_n) begin
            pending_writes.delete();
            row_pos    = '0;
            col_pos    = '0;
            column_sum = '0;
            grand_sum  = '0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tuser, i_m_tdata[17:0], i_m_tdata[50:18], i_m_tlast};
                if (pending_writes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected write, expected none, %s %0d %0d %0d %0d",
                             $time, "got table/addr/value/last",
                             got.to_table, got.address, got.value, got.is_last);
                end else begin
                    want = pending_writes.pop_front();
                    if (got.to_table !== want.to_table || got.address !== want.address ||
                        got.value !== want.value || got.is_last !== want.is_last) begin
                        mismatch_count++;
                        $display("%0t: write mismatch, expected table %0d addr %0d %s",
                                 $time, want.to_table, want.address, "value/last");
                        $display("    expected value %0d last %0d",
                                 want.value, want.is_last);
                        $display("    got table %0d addr %0d value %0d last %0d",
                                 got.to_table, got.address, got.value, got.is_last);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) predict_texel(i_s_tdata);
        end
        o_mismatches <= mismatch_count;
        o_pending    <= pending_writes.size();
    end

endmodule

### tb/tb_top.sv
// Testbench top for the sky luminance CDF builder: clock, reset, texel stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 12;
    localparam int PHASE_TEXELS   = 110;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int QUIET_LIMIT    = 4000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;    // red [15:0], green [31:16], blue [47:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;    // write_address [17:0], cdf_value [50:18], zero
    logic        m_axis_tuser;    // target_table [0]
    logic        m_axis_tlast;

    int          mismatches;
    int          pending;
    int          texels_sent  = 0;
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    int          hold_at      = 32'h7fff_ffff;
    int          quiet_cycles = 0;

    always #2 clk = ~clk;

    sky_luminance_cdf_builder_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser),
        .o_m_axis_tlast  (m_axis_tlast)
    );

    cdf_write_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Texel corner cases: zeros, full scale, single channels, bit patterns
    localparam logic [47:0] CORNER_TEXELS [20] = '{
        48'h0000_0000_0000, 48'hffff_ffff_ffff, 48'h0000_0000_ffff, 48'h0000_ffff_0000,
        48'hffff_0000_0000, 48'haaaa_5555_aaaa, 48'h5555_aaaa_5555, 48'h0001_0001_0001,
        48'h8000_8000_8000, 48'h0080_ff00_00ff, 48'hffff_ffff_ffff, 48'h7fff_7fff_7fff,
        48'h0000_0001_0000, 48'hff00_00ff_f0f0, 48'h0f0f_f0f0_0f0f, 48'hffff_ffff_ffff,
        48'h0000_0000_0000, 48'h1234_5678_9abc, 48'hffff_0000_ffff, 48'hffff_ffff_ffff
    };

    // Receiver: random back-pressure, plus one long hold-off while texels keep coming
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!hold_done && texels_sent >= hold_at) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: too long without any request moving on either side
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Offer one texel, idling first at the sender's rate, until it is taken
    task automatic offer_texel(input logic [47:0] texel);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= texel;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        texels_sent++;
    endtask

    // Stop offering and wait until every predicted write has been seen
    task automatic await_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Channels drawn independently: full scale, zero, dim or fully random
    function automatic logic [47:0] random_texel();
        logic [15:0] ch [3];
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(9))
                0:       ch[i] = 16'hffff;
                1:       ch[i] = 16'h0000;
                2:       ch[i] = 16'($urandom_range(255));
                default: ch[i] = 16'($urandom);
            endcase
        end
        return {ch[2], ch[1], ch[0]};
    endfunction

    initial begin : stimulus
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // slow receiver
        tx_idle_pct = 22;
        rx_idle_pct = 84;
        foreach (CORNER_TEXELS[i]) offer_texel(CORNER_TEXELS[i]);
        repeat (PHASE_TEXELS) offer_texel(random_texel());
        await_drain();

        // slow sender
        tx_idle_pct = 84;
        rx_idle_pct = 22;
        repeat (PHASE_TEXELS) offer_texel(random_texel());
        await_drain();

        // full rate, with one long receiver hold-off to fill the block
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_at     = texels_sent + 20;
        repeat (PHASE_TEXELS) offer_texel(random_texel());
        await_drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
